// ===== design/key_matrix_debounce_events_assert.svh =====
// Assertion macros shared by the key matrix debounce event RTL.
`ifndef KEY_MATRIX_DEBOUNCE_EVENTS_ASSERT_SVH
`define KEY_MATRIX_DEBOUNCE_EVENTS_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define KMD_ASSERT_NOW(label, clk, rst_n, cause, effect) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cause) |-> (effect)) \
        else $error("kmd assertion failed");

// Next-cycle implication, checked outside reset.
`define KMD_ASSERT_NEXT(label, clk, rst_n, cause, effect) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cause) |=> (effect)) \
        else $error("kmd assertion failed");

`endif

// ===== design/kmd_pkg.sv =====
// Package with the shared types and constants of the key matrix debounce block.
`timescale 1ns / 1ps
package kmd_pkg;

    localparam int COLS      = 8;
    localparam int ROWS      = 8;
    localparam int TIME_BITS = 32;
    localparam int COL_W     = 3;
    localparam int ROW_W     = 3;
    localparam int DBMS_W    = 16;

    localparam logic [DBMS_W-1:0] DEBOUNCE_RESET = 16'd20;

    typedef logic [COL_W-1:0]     t_col;
    typedef logic [ROW_W-1:0]     t_row;
    typedef logic [ROWS-1:0]      t_rowvec;
    typedef logic [TIME_BITS-1:0] t_time;
    typedef logic [DBMS_W-1:0]    t_dbms;

    // State of the keys of one column, indexed by bit position (row = ROWS-1-bit).
    typedef struct packed {
        t_rowvec               level;
        t_rowvec               debounced;
        logic [ROWS-1:0][TIME_BITS-1:0] stamp;
    } t_col_state;

    // Events caused by one scanned column.
    typedef struct packed {
        t_rowvec mask;
        t_rowvec press;
        t_col    column;
    } t_events;

endpackage

// ===== design/kmd_key_update.sv =====
// Per-column key update: new levels, debounce flags, press times and events.
`timescale 1ns / 1ps
module kmd_key_update (
    input  kmd_pkg::t_col_state i_cur,
    input  kmd_pkg::t_rowvec    i_row_bits,
    input  kmd_pkg::t_time      i_now_ms,
    input  kmd_pkg::t_dbms      i_debounce_ms,
    output kmd_pkg::t_col_state o_nxt,
    output kmd_pkg::t_rowvec    o_ev_mask,
    output kmd_pkg::t_rowvec    o_ev_press
);
    import kmd_pkg::*;

    always_comb begin
        logic  down;
        t_time elapsed;
        o_nxt      = i_cur;
        o_ev_mask  = '0;
        o_ev_press = '0;
        for (int b = 0; b < ROWS; b++) begin
            down    = ~i_row_bits[b];
            elapsed = i_now_ms - i_cur.stamp[b];
            if (down != i_cur.level[b]) begin
                o_nxt.level[b] = down;
                if (down) begin
                    o_nxt.stamp[b] = i_now_ms;
                end else begin
                    // A release reports only a key that had been debounced.
                    o_ev_mask[b]       = i_cur.debounced[b];
                    o_nxt.debounced[b] = 1'b0;
                end
            end else if (i_cur.level[b] && !i_cur.debounced[b]
                         && (elapsed > TIME_BITS'(i_debounce_ms))) begin
                o_ev_mask[b]       = 1'b1;
                o_ev_press[b]      = 1'b1;
                o_nxt.debounced[b] = 1'b1;
            end
        end
    end

endmodule

// ===== design/kmd_event_queue.sv =====
// Event register that hands out the events of one column, one word per cycle while i_stall is low.
`timescale 1ns / 1ps
module kmd_event_queue (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_load,
    input  kmd_pkg::t_events i_events,
    output logic             o_free,
    output logic             o_valid,
    input  logic             i_stall,
    output kmd_pkg::t_col    o_event_column,
    output kmd_pkg::t_row    o_event_row,
    output logic             o_pressed,
    output logic             o_last
);
    import kmd_pkg::*;

    t_rowvec r_mask, n_mask;
    t_rowvec r_press;
    t_col    r_col;
    t_rowvec rest;
    t_row    idx;
    logic    take;

    // Lowest set bit is the highest row, which goes out first.
    always_comb begin
        idx = '0;
        for (int b = ROWS - 1; b >= 0; b--) begin
            if (r_mask[b]) begin
                idx = ROW_W'(b);
            end
        end
    end

    assign rest           = r_mask & (r_mask - 1'b1);
    assign o_valid        = |r_mask;
    assign take           = o_valid && !i_stall;
    assign o_free         = !o_valid || (take && (rest == '0));
    assign o_event_column = r_col;
    assign o_event_row    = ROW_W'(ROWS - 1) - idx;
    assign o_pressed      = r_press[idx];
    assign o_last         = (rest == '0);

    always_comb begin
        n_mask = r_mask;
        if (i_load) begin
            n_mask = i_events.mask;
        end else if (take) begin
            n_mask = rest;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mask <= '0;
        end else begin
            r_mask <= n_mask;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_press <= i_events.press;
            r_col   <= i_events.column;
        end
    end

endmodule

// ===== design/key_matrix_debounce_events.sv =====
// Key matrix debounce: one scanned column in, press and release event words out.
// A taken column word is registered; its events are then loaded into the event register.
// Throughput: one column word per cycle while each causes at most one event and i_stall
// is low; a column with more events holds the event register, one event word per unstalled cycle.
// Reset (synchronous, active low) releases all keys, clears debounce flags, sets 20 ms.
`timescale 1ns / 1ps
`include "key_matrix_debounce_events_assert.svh"
module key_matrix_debounce_events (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    output logic            o_stall,
    input  kmd_pkg::t_col   i_column,
    input  logic [7:0]      i_row_bits,
    input  kmd_pkg::t_time  i_now_ms,
    input  logic            i_cfg_valid,
    output logic            o_cfg_ready,
    input  kmd_pkg::t_dbms  i_cfg_data,
    output logic            o_valid,
    input  logic            i_stall,
    output kmd_pkg::t_col   o_event_column,
    output kmd_pkg::t_row   o_event_row,
    output logic            o_pressed,
    output logic            o_last
);
    import kmd_pkg::*;

    t_dbms      r_debounce;
    logic       r_in_v, n_in_v;
    t_col       r_col;
    t_rowvec    r_bits;
    t_time      r_now;
    t_rowvec    r_lvl [COLS];
    t_rowvec    r_deb [COLS];
    logic [ROWS-1:0][TIME_BITS-1:0] r_stamp [COLS];
    t_col_state cur, nxt;
    t_rowvec    ev_mask, ev_press;
    t_events    events;
    logic       q_free, fire, accept;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_debounce <= DEBOUNCE_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_debounce <= i_cfg_data;
        end
    end

    // A column without events updates its keys without waiting for the event register.
    assign fire    = r_in_v && (q_free || (ev_mask == '0));
    assign o_stall = r_in_v && !fire;
    assign accept  = i_valid && !o_stall;

    always_comb begin
        n_in_v = r_in_v;
        if (accept) begin
            n_in_v = 1'b1;
        end else if (fire) begin
            n_in_v = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_v <= 1'b0;
        end else begin
            r_in_v <= n_in_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_col  <= i_column;
            r_bits <= i_row_bits;
            r_now  <= i_now_ms;
        end
    end

    assign cur.level     = r_lvl[r_col];
    assign cur.debounced = r_deb[r_col];
    assign cur.stamp     = r_stamp[r_col];

    kmd_key_update u_update (
        .i_cur         (cur),
        .i_row_bits    (r_bits),
        .i_now_ms      (r_now),
        .i_debounce_ms (r_debounce),
        .o_nxt         (nxt),
        .o_ev_mask     (ev_mask),
        .o_ev_press    (ev_press)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int c = 0; c < COLS; c++) begin
                r_lvl[c] <= '0;
                r_deb[c] <= '0;
            end
        end else if (fire) begin
            r_lvl[r_col] <= nxt.level;
            r_deb[r_col] <= nxt.debounced;
        end
    end

    // Press times are read only for keys that are down, so they need no reset.
    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_stamp[r_col] <= nxt.stamp;
        end
    end

    assign events.mask   = ev_mask;
    assign events.press  = ev_press;
    assign events.column = r_col;

    kmd_event_queue u_queue (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_load         (fire && (ev_mask != '0)),
        .i_events       (events),
        .o_free         (q_free),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_event_column (o_event_column),
        .o_event_row    (o_event_row),
        .o_pressed      (o_pressed),
        .o_last         (o_last)
    );

    `KMD_ASSERT_NOW(a_stall_needs_item, i_clk, i_rst_n, o_stall, r_in_v)
    `KMD_ASSERT_NEXT(a_more_after_not_last, i_clk, i_rst_n, o_valid && !i_stall && !o_last, o_valid)
    `KMD_ASSERT_NOW(a_debounced_is_down, i_clk, i_rst_n, r_in_v, (cur.debounced & ~cur.level) == '0)

endmodule
